// ----- hdl/urav_pkg.sv -----
// Shared types, constants and register codes of the ultrasonic range averager.
// Used by every module of the block but urav_ram, and by its checker; depends on nothing.
package urav_pkg;

	// field widths
	localparam int DIST_W    = 22;
	localparam int TICK_W    = 32;
	localparam int TRIG_W    = 16;
	localparam int SCALE_W   = 24;
	localparam int KIND_W    = 2;
	localparam int HALF_W    = 16;
	localparam int PROD_W    = HALF_W + SCALE_W;

	localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};
	localparam int ROUND_HALF = 32768;

	// stream packing
	localparam int S_TDATA_W = 8;
	localparam int M_TDATA_W = 48;
	localparam int M_TUSER_W = 3;
	localparam int DIST_LSB  = 1;
	localparam int AVG_LSB   = DIST_LSB + DIST_W;
	localparam int KIND_LSB  = 1;

	// timeout kinds
	localparam logic [KIND_W-1:0] KIND_NONE  = 2'd0;
	localparam logic [KIND_W-1:0] KIND_START = 2'd1;
	localparam logic [KIND_W-1:0] KIND_WIDTH = 2'd2;

	// register indexes
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 32;
	localparam logic [CFG_IDX_W-1:0] CFG_TRIGGER  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_INTERVAL = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_SCALE    = 2'd3;

	// register reset values
	localparam logic [TRIG_W-1:0]  TRIGGER_RST  = 16'd10;
	localparam logic [TICK_W-1:0]  TIMEOUT_RST  = 32'd2000000;
	localparam logic [TICK_W-1:0]  INTERVAL_RST = 32'd100000;
	localparam logic [SCALE_W-1:0] SCALE_RST    = 24'd112394;

	localparam int QUEUE_DEPTH     = 4;
	localparam int RING_DEPTH_DFLT = 10;

	typedef struct packed {
		logic [TRIG_W-1:0]  trigger_ticks;
		logic [TICK_W-1:0]  timeout_ticks;
		logic [TICK_W-1:0]  interval_ticks;
		logic [SCALE_W-1:0] scale_q16;
	} cfg_t;

	// one classified tick, handed from the front end to the back end
	typedef struct packed {
		logic              trig;
		logic              finish;
		logic [KIND_W-1:0] kind;
		logic [TICK_W-1:0] width;
	} job_t;

	typedef struct packed {
		logic              trigger_level;
		logic              sample_valid;
		logic [DIST_W-1:0] distance;
		logic [DIST_W-1:0] average_distance;
		logic [KIND_W-1:0] timeout_kind;
	} res_t;

endpackage

// ----- hdl/urav_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
// Stand-alone; no package.
module urav_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             rd_en,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

// ----- hdl/urav_front.sv -----
// Front end: trigger / echo phase sequencer that classifies every accepted tick.
// Depends on urav_pkg for the configuration and job types.
module urav_front (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           accept,
	input  logic           echo_level,
	input  logic           run_enable,
	input  urav_pkg::cfg_t cfg,
	output urav_pkg::job_t job
);

	typedef enum logic [4:0] {
		PH_IDLE = 5'b00001,
		PH_TRIG = 5'b00010,
		PH_RISE = 5'b00100,
		PH_HIGH = 5'b01000,
		PH_WAIT = 5'b10000
	} phase_t;

	phase_t                      phase_q, phase_d;
	logic [urav_pkg::TICK_W-1:0] tick_q, tick_d, tick_inc;

	assign tick_inc = tick_q + urav_pkg::TICK_W'(1);

	always_comb begin
		phase_d = phase_q;
		tick_d  = tick_q;
		job     = '0;
		if (!run_enable) begin
			phase_d = PH_IDLE;
			tick_d  = '0;
		end else begin
			case (phase_q)
				PH_TRIG: begin
					if (tick_q < urav_pkg::TICK_W'(cfg.trigger_ticks)) begin
						job.trig = 1'b1;
						tick_d   = tick_inc;
					end else begin
						phase_d = PH_RISE;
						tick_d  = '0;
					end
				end
				PH_RISE: begin
					if (echo_level) begin
						phase_d = PH_HIGH;
						tick_d  = urav_pkg::TICK_W'(1);
					end else if (tick_inc >= cfg.timeout_ticks) begin
						job.kind = urav_pkg::KIND_START;
						phase_d  = PH_WAIT;
						tick_d   = '0;
					end else begin
						tick_d = tick_inc;
					end
				end
				PH_HIGH: begin
					if (echo_level && (tick_q < cfg.timeout_ticks)) begin
						tick_d = tick_inc;
					end else begin
						// echo fell or width hit the limit: hand the width on
						job.finish = 1'b1;
						job.kind   = echo_level ? urav_pkg::KIND_WIDTH : urav_pkg::KIND_NONE;
						job.width  = tick_q;
						phase_d    = PH_WAIT;
						tick_d     = '0;
					end
				end
				PH_WAIT: begin
					if (tick_q >= cfg.interval_ticks) begin
						job.trig = 1'b1;
						phase_d  = PH_TRIG;
						tick_d   = urav_pkg::TICK_W'(1);
					end else begin
						tick_d = tick_inc;
					end
				end
				default: begin
					job.trig = 1'b1;
					phase_d  = PH_TRIG;
					tick_d   = urav_pkg::TICK_W'(1);
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			tick_q  <= '0;
		end else if (accept) begin
			phase_q <= phase_d;
			tick_q  <= tick_d;
		end
	end

endmodule

// ----- hdl/urav_fifo.sv -----
// Short job queue between the front end and the back end.
// Depends on urav_pkg for the job type and queue depth.
module urav_fifo (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  urav_pkg::job_t push_job,
	output logic           full,
	input  logic           pop,
	output urav_pkg::job_t head,
	output logic           empty
);

	localparam int DEPTH = urav_pkg::QUEUE_DEPTH;
	localparam int PW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW    = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] PTR_LAST = PW'(DEPTH - 1);

	urav_pkg::job_t mem_q [DEPTH];
	logic [PW-1:0]  wr_ptr_q, rd_ptr_q;
	logic [CW-1:0]  count_q;

	assign full  = (count_q == CW'(DEPTH));
	assign empty = (count_q == '0);
	assign head  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + PW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + PW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CW'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

endmodule

// ----- hdl/urav_back.sv -----
// Back end: scales finished widths, updates the distance ring and running sum,
// divides for the average and holds the result register. Uses urav_pkg and urav_ram.
module urav_back #(
	parameter int RING_DEPTH = urav_pkg::RING_DEPTH_DFLT
) (
	input  logic           clk,
	input  logic           arst_n,
	input  urav_pkg::cfg_t cfg,
	input  urav_pkg::job_t head,
	input  logic           empty,
	output logic           pop,
	output logic           res_valid,
	input  logic           res_ready,
	output urav_pkg::res_t res
);

	localparam int DIST_W = urav_pkg::DIST_W;
	localparam int PROD_W = urav_pkg::PROD_W;
	localparam int HALF_W = urav_pkg::HALF_W;
	localparam int AW     = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
	localparam int CNT_W  = $clog2(RING_DEPTH + 1);
	localparam int SUM_W  = DIST_W + CNT_W;
	localparam int DC_W   = $clog2(SUM_W);
	localparam logic [AW-1:0] POS_LAST = AW'(RING_DEPTH - 1);

	typedef enum logic [6:0] {
		B_IDLE   = 7'b0000001,
		B_MUL_LO = 7'b0000010,
		B_MUL_HI = 7'b0000100,
		B_SCALE  = 7'b0001000,
		B_UPD    = 7'b0010000,
		B_DIV    = 7'b0100000,
		B_OUT    = 7'b1000000
	} bstate_t;

	bstate_t            bst_q;
	urav_pkg::job_t     job_q;
	logic [PROD_W-1:0]  prod_lo_q, prod_hi_q;
	logic [PROD_W:0]    lo_round, scaled;
	logic [DIST_W-1:0]  dist_sat, dist_q, old_d, rd_data, avg_sat;
	logic [AW-1:0]      pos_q;
	logic [RING_DEPTH-1:0] ring_vld_q;
	logic [SUM_W-1:0]   sum_q, sum_next, quo_q;
	logic [CNT_W-1:0]   cnt_q, cnt_next, rem_q, rem_d;
	logic [CNT_W:0]     trial, diff;
	logic               ge;
	logic [DC_W-1:0]    div_cnt_q;
	logic               out_free, out_load;

	urav_ram #(
		.WIDTH (DIST_W),
		.DEPTH (RING_DEPTH),
		.AW    (AW)
	) u_ring (
		.clk     (clk),
		.wr_en   (bst_q == B_UPD),
		.wr_addr (pos_q),
		.wr_data (dist_q),
		.rd_en   (bst_q == B_MUL_LO),
		.rd_addr (pos_q),
		.rd_data (rd_data)
	);

	assign out_free = !res_valid || res_ready;
	assign pop      = (bst_q == B_IDLE) && !empty && (head.finish || out_free);
	assign out_load = (pop && !head.finish) || ((bst_q == B_OUT) && out_free);

	// round to nearest: (w * s + 2^15) >> 16, split over the two width halves
	assign lo_round = {1'b0, prod_lo_q} + (PROD_W + 1)'(urav_pkg::ROUND_HALF);
	assign scaled   = {1'b0, prod_hi_q} + (lo_round >> HALF_W);
	assign dist_sat = (scaled > (PROD_W + 1)'(urav_pkg::DIST_MAX)) ?
		urav_pkg::DIST_MAX : scaled[DIST_W-1:0];

	// an entry never written since reset reads as zero
	assign old_d    = ring_vld_q[pos_q] ? rd_data : '0;
	assign sum_next = sum_q - SUM_W'(old_d) + SUM_W'(dist_q);
	assign cnt_next = cnt_q - CNT_W'(old_d != '0) + CNT_W'(dist_q != '0);

	// restoring divide, one quotient bit a cycle
	assign trial = {rem_q, quo_q[SUM_W-1]};
	assign ge    = (trial >= {1'b0, cnt_q});
	assign diff  = trial - {1'b0, cnt_q};
	assign rem_d = ge ? diff[CNT_W-1:0] : trial[CNT_W-1:0];

	assign avg_sat = (cnt_q == '0) ? '0 :
		(quo_q > SUM_W'(urav_pkg::DIST_MAX)) ? urav_pkg::DIST_MAX : quo_q[DIST_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bst_q      <= B_IDLE;
			res_valid  <= 1'b0;
			pos_q      <= '0;
			ring_vld_q <= '0;
			sum_q      <= '0;
			cnt_q      <= '0;
		end else begin
			if (out_load) begin
				res_valid <= 1'b1;
			end else if (res_ready) begin
				res_valid <= 1'b0;
			end
			case (bst_q)
				B_IDLE: begin
					if (pop && head.finish) begin
						bst_q <= B_MUL_LO;
					end
				end
				B_MUL_LO: bst_q <= B_MUL_HI;
				B_MUL_HI: bst_q <= B_SCALE;
				B_SCALE:  bst_q <= B_UPD;
				B_UPD: begin
					ring_vld_q[pos_q] <= 1'b1;
					sum_q <= sum_next;
					cnt_q <= cnt_next;
					pos_q <= (pos_q == POS_LAST) ? '0 : pos_q + AW'(1);
					bst_q <= B_DIV;
				end
				B_DIV: begin
					if (div_cnt_q == '0) begin
						bst_q <= B_OUT;
					end
				end
				B_OUT: begin
					if (out_free) begin
						bst_q <= B_IDLE;
					end
				end
				default: bst_q <= B_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			job_q <= head;
		end
		if (bst_q == B_MUL_LO) begin
			prod_lo_q <= PROD_W'(job_q.width[HALF_W-1:0]) * PROD_W'(cfg.scale_q16);
		end
		if (bst_q == B_MUL_HI) begin
			prod_hi_q <= PROD_W'(job_q.width[2*HALF_W-1:HALF_W]) * PROD_W'(cfg.scale_q16);
		end
		if (bst_q == B_SCALE) begin
			dist_q <= dist_sat;
		end
		if (bst_q == B_UPD) begin
			quo_q     <= sum_next;
			rem_q     <= '0;
			div_cnt_q <= DC_W'(SUM_W - 1);
		end else if (bst_q == B_DIV) begin
			quo_q     <= {quo_q[SUM_W-2:0], ge};
			rem_q     <= rem_d;
			div_cnt_q <= div_cnt_q - DC_W'(1);
		end
		if (out_load) begin
			if (bst_q == B_OUT) begin
				res.trigger_level    <= job_q.trig;
				res.sample_valid     <= 1'b1;
				res.distance         <= dist_q;
				res.average_distance <= avg_sat;
				res.timeout_kind     <= job_q.kind;
			end else begin
				res.trigger_level    <= head.trig;
				res.sample_valid     <= 1'b0;
				res.distance         <= '0;
				res.average_distance <= '0;
				res.timeout_kind     <= head.kind;
			end
		end
	end

endmodule

// ----- hdl/ultrasonic_range_averager.sv -----
// Top level of the ultrasonic range averager: configuration registers, stream packing,
// and the front end, job queue and back end. Uses urav_pkg, urav_front, urav_fifo, urav_back.
//
// Each input request is one timer tick carrying the sampled echo pin and the run enable;
// each tick gives exactly one output request, in order. While enabled the block drives a
// trigger pulse, waits for echo to rise, times its high width (both waits bounded by
// timeout_ticks), converts the width to hundredths of a centimetre with scale_q16 (rounded,
// saturated to 22 bits), stores it in a ring of RING_DEPTH recent distances and reports the
// ring sum divided by the count of nonzero entries, then idles interval_ticks before the
// next trigger. The front end sequences the phases and classifies one tick per cycle while
// the job queue has room; a four-deep job queue decouples it from the back end. Ticks that
// end no measurement are loaded into the result register as they leave the queue. A tick
// that ends a measurement holds the back end while it takes the job from the queue, runs
// a split 16 x 24 multiply in two halves, rounds, updates the ring through the RAM port,
// divides bit-serially over the SUM_W quotient bits and loads the result; the queue
// absorbs the ticks that arrive meanwhile and s_tready drops only when it fills. The ring
// valid bits, running sum and count are cleared by reset with no clearing pass; unwritten
// ring entries read as zero. Configuration writes are always taken (cfg_ready is tied high)
// and must only occur while the block is idle.
module ultrasonic_range_averager #(
	parameter int RING_DEPTH = urav_pkg::RING_DEPTH_DFLT
) (
	input  logic                               clk,
	input  logic                               arst_n,
	// s_tdata: [0] echo_level, [1] run_enable, [7:2] zero
	input  logic                               s_tvalid,
	output logic                               s_tready,
	input  logic [urav_pkg::S_TDATA_W-1:0]     s_tdata,
	// m_tdata: [0] trigger_level, [22:1] distance, [44:23] average_distance, [47:45] zero
	// m_tuser: [0] sample_valid, [2:1] timeout_kind
	output logic                               m_tvalid,
	input  logic                               m_tready,
	output logic [urav_pkg::M_TDATA_W-1:0]     m_tdata,
	output logic [urav_pkg::M_TUSER_W-1:0]     m_tuser,
	// configuration writes: index 0 trigger, 1 timeout, 2 interval, 3 scale
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [urav_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [urav_pkg::CFG_DATA_W-1:0]    cfg_data
);

	localparam int PAD_W = urav_pkg::M_TDATA_W - 1 - 2 * urav_pkg::DIST_W;

	urav_pkg::cfg_t cfg_q;
	urav_pkg::job_t job, head;
	urav_pkg::res_t res;
	logic           accept, fifo_full, fifo_empty, pop;

	// configuration registers: accept every write, ignore nothing but unknown codes
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.trigger_ticks  <= urav_pkg::TRIGGER_RST;
			cfg_q.timeout_ticks  <= urav_pkg::TIMEOUT_RST;
			cfg_q.interval_ticks <= urav_pkg::INTERVAL_RST;
			cfg_q.scale_q16      <= urav_pkg::SCALE_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				urav_pkg::CFG_TRIGGER:  cfg_q.trigger_ticks  <= cfg_data[urav_pkg::TRIG_W-1:0];
				urav_pkg::CFG_TIMEOUT:  cfg_q.timeout_ticks  <= cfg_data;
				urav_pkg::CFG_INTERVAL: cfg_q.interval_ticks <= cfg_data;
				urav_pkg::CFG_SCALE:    cfg_q.scale_q16      <= cfg_data[urav_pkg::SCALE_W-1:0];
				default: ;
			endcase
		end
	end

	// hold off input requests only when the job queue is full
	assign s_tready = !fifo_full;
	assign accept   = s_tvalid && s_tready;

	urav_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.accept     (accept),
		.echo_level (s_tdata[0]),
		.run_enable (s_tdata[1]),
		.cfg        (cfg_q),
		.job        (job)
	);

	urav_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (accept),
		.push_job (job),
		.full     (fifo_full),
		.pop      (pop),
		.head     (head),
		.empty    (fifo_empty)
	);

	urav_back #(
		.RING_DEPTH (RING_DEPTH)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.head      (head),
		.empty     (fifo_empty),
		.pop       (pop),
		.res_valid (m_tvalid),
		.res_ready (m_tready),
		.res       (res)
	);

	// pack the result register onto the output stream
	assign m_tdata = {{PAD_W{1'b0}}, res.average_distance, res.distance, res.trigger_level};
	assign m_tuser = {res.timeout_kind, res.sample_valid};

endmodule

// ----- hdl/urav_checker.sv -----
// Port-level checker for the ultrasonic range averager, bound to the top level.
// Depends on urav_pkg for field positions and timeout kind codes.
module urav_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           m_tvalid,
	input logic                           m_tready,
	input logic [urav_pkg::M_TDATA_W-1:0] m_tdata,
	input logic [urav_pkg::M_TUSER_W-1:0] m_tuser
);

	localparam int DW = urav_pkg::DIST_W;

	logic [DW-1:0]               cur_dist, avg;
	logic [urav_pkg::KIND_W-1:0] kind;

	assign cur_dist = m_tdata[urav_pkg::DIST_LSB +: DW];
	assign avg      = m_tdata[urav_pkg::AVG_LSB +: DW];
	assign kind     = m_tuser[urav_pkg::KIND_LSB +: urav_pkg::KIND_W];

	// hold a stalled result
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("stalled result changed");

	// a tick without a new sample carries no distance and no average
	a_no_sample_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser[0] |-> cur_dist == '0 && avg == '0)
		else $error("distance reported without a sample");

	// start timeout stores nothing; width timeout is always a stored sample
	a_kind_match: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (kind != urav_pkg::KIND_START || !m_tuser[0]) &&
		             (kind != urav_pkg::KIND_WIDTH || m_tuser[0]))
		else $error("timeout kind disagrees with sample flag");

	// a sample never falls on a trigger tick
	a_sample_no_trig: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[0] |-> !m_tdata[0])
		else $error("sample reported during trigger");

	// a nonzero new distance makes the average nonzero
	a_avg_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[0] && cur_dist != '0 |-> avg != '0)
		else $error("zero average after nonzero distance");

endmodule

bind ultrasonic_range_averager urav_checker u_urav_checker (.*);
